### hw/rtl/lkv_pkg.sv
package lkv_pkg;

  localparam int CAPACITY = 64;
  localparam int RANK_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 64;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 2;

  typedef logic [RANK_W-1:0]  rank_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Operation codes of a request.
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIMIT = 2'd2;

  // Update actions broadcast to the cells.
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_TOUCH  = 3'd1;
  localparam logic [2:0] ACT_WRITE  = 3'd2;
  localparam logic [2:0] ACT_INSERT = 3'd3;
  localparam logic [2:0] ACT_REMOVE = 3'd4;

  typedef struct packed {
    logic             capture;
    logic [2:0]       act;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] key_mask;
    logic [VAL_W-1:0] value;
    rank_t            rank_ref;
    rank_t            last_rank;
    logic             evict;
  } cell_cmd_t;

  typedef struct packed {
    logic             valid;
    logic             hit_sel;
    logic             free_sel;
    rank_t            rank;
    logic [VAL_W-1:0] value;
  } cell_view_t;

  // Mask of the low n bytes; a count of zero acts as one, above eight as eight.
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [3:0]  nn;
    logic [63:0] m;
    nn = (n == 4'd0) ? 4'd1 : ((n > 4'd8) ? 4'd8 : n);
    m  = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < nn) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

### hw/rtl/lkv_req_if.sv
interface lkv_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] key;
  logic [63:0] value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink   (input valid, input op, input key, input value, output ready);
endinterface

### hw/rtl/lkv_rsp_if.sv
interface lkv_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [63:0] value_out;
  logic        evicted;

  modport source (output valid, output status, output value_out, output evicted,
                  input ready);
  modport sink   (input valid, input status, input value_out, input evicted,
                  output ready);
endinterface

### hw/rtl/lkv_cell.sv
module lkv_cell (
  input  logic               clk,
  input  logic               rst,
  input  lkv_pkg::cell_cmd_t cmd,
  input  logic               hit_seen_in,
  input  logic               free_seen_in,
  output logic               hit_seen_out,
  output logic               free_seen_out,
  output lkv_pkg::cell_view_t view
);
  import lkv_pkg::*;

  logic             valid;
  logic [KEY_W-1:0] stored_key;
  logic [VAL_W-1:0] stored_value;
  rank_t            rank;
  logic             hit_sel;
  logic             free_sel;

  logic match;
  logic oldest;
  logic avail;

  assign match  = valid && ((stored_key & cmd.key_mask) == cmd.key);
  assign oldest = valid && (rank == cmd.last_rank);
  // The oldest entry counts as free when this insert evicts it.
  assign avail  = !valid || (cmd.evict && oldest);

  assign hit_seen_out  = hit_seen_in || match;
  assign free_seen_out = free_seen_in || avail;

  assign view.valid    = valid;
  assign view.hit_sel  = hit_sel;
  assign view.free_sel = free_sel;
  assign view.rank     = rank;
  assign view.value    = stored_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      rank     <= '0;
      hit_sel  <= 1'b0;
      free_sel <= 1'b0;
    end else begin
      if (cmd.capture) begin
        hit_sel  <= match && !hit_seen_in;
        free_sel <= avail && !free_seen_in;
      end
      case (cmd.act)
        ACT_TOUCH, ACT_WRITE: begin
          if (hit_sel) begin
            rank <= '0;
          end else if (valid && (rank < cmd.rank_ref)) begin
            rank <= rank_t'(rank + 1'b1);
          end
        end
        ACT_INSERT: begin
          if (free_sel) begin
            valid <= 1'b1;
            rank  <= '0;
          end else if (cmd.evict && oldest) begin
            valid <= 1'b0;
            rank  <= '0;
          end else if (valid) begin
            rank <= rank_t'(rank + 1'b1);
          end
        end
        ACT_REMOVE: begin
          if (hit_sel) begin
            valid <= 1'b0;
            rank  <= '0;
          end else if (valid && (rank > cmd.rank_ref)) begin
            rank <= rank_t'(rank - 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.act == ACT_WRITE) && hit_sel) begin
      stored_value <= cmd.value;
    end
    if ((cmd.act == ACT_INSERT) && free_sel) begin
      stored_key   <= cmd.key;
      stored_value <= cmd.value;
    end
  end

endmodule

### hw/rtl/lru_key_value_map.sv
// Channel  Role    Payload                       Transfer
// -------  ------  ----------------------------  ------------------------
// req      sink    op, key, value                req.valid && req.ready
// rsp      source  status, value_out, evicted    rsp.valid && rsp.ready
// cfg      write   cfg_index, cfg_data           cfg_we high at the edge
//
// An item passes these steps in order: accept, compare along the cell chain, reduce the
// selected cell, then update all cells at once while the result is registered.
// The control takes one item at a time.
// Reset (synchronous, active high) empties the store and loads the default
// configuration. A result waiting in the output register holds the update
// step until it is transferred; a new request is taken once the update is done.
module lru_key_value_map (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lkv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lkv_pkg::CFG_W-1:0]     cfg_data,
  lkv_req_if.sink                       req,
  lkv_rsp_if.source                     rsp
);
  import lkv_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_SEL  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [3:0] key_bytes;
  logic [3:0] value_bytes;
  logic [6:0] entry_limit;

  logic [1:0]       req_op;
  logic [KEY_W-1:0] req_key;
  logic [VAL_W-1:0] req_value;
  count_t           count;

  logic             hit_any;
  rank_t            hit_rank;
  logic [VAL_W-1:0] hit_value;

  logic             out_valid;
  logic             out_status;
  logic [VAL_W-1:0] out_value;
  logic             out_evicted;

  logic [KEY_W-1:0] kmask;
  logic [VAL_W-1:0] vmask;
  count_t           limit_now;
  logic             evict_now;
  logic             out_free;
  logic             accept;
  logic             finish;
  logic [2:0]       act_sel;
  logic             res_status;
  logic             res_evicted;
  logic [VAL_W-1:0] res_value;

  cell_cmd_t  cmd;
  cell_view_t views [CAPACITY];
  logic [CAPACITY:0] hit_chain;
  logic [CAPACITY:0] free_chain;

  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY-1:0] free_vec;
  logic [CAPACITY-1:0] valid_vec;
  rank_t               or_rank;
  logic [VAL_W-1:0]    or_value;

  assign kmask = byte_mask(key_bytes);
  assign vmask = byte_mask(value_bytes);

  always_comb begin
    if (entry_limit == 7'd0) begin
      limit_now = count_t'(1);
    end else if (32'(entry_limit) > CAPACITY) begin
      limit_now = count_t'(CAPACITY);
    end else begin
      limit_now = count_t'(entry_limit);
    end
  end

  assign evict_now = (count >= limit_now);
  assign out_free  = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign finish    = (state == S_UPD) && out_free;

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.value_out = out_value;
  assign rsp.evicted   = out_evicted;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes   <= 4'd8;
      value_bytes <= 4'd8;
      entry_limit <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_BYTES:   key_bytes   <= cfg_data[3:0];
        REG_VALUE_BYTES: value_bytes <= cfg_data[3:0];
        REG_ENTRY_LIMIT: entry_limit <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (state)
      S_IDLE:  state_next = accept ? S_CMP : S_IDLE;
      S_CMP:   state_next = S_SEL;
      S_SEL:   state_next = S_UPD;
      S_UPD:   state_next = out_free ? S_IDLE : S_UPD;
      default: state_next = S_IDLE;
    endcase
  end

  // Result and cell action for the request in hand.
  always_comb begin
    act_sel     = ACT_NONE;
    res_status  = 1'b0;
    res_evicted = 1'b0;
    res_value   = '0;
    case (req_op)
      OP_LOOKUP: begin
        if (hit_any) begin
          act_sel   = ACT_TOUCH;
          res_value = hit_value & vmask;
        end else begin
          res_status = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (hit_any) begin
          act_sel = ACT_WRITE;
        end else begin
          act_sel     = ACT_INSERT;
          res_evicted = evict_now;
        end
      end
      OP_DELETE: begin
        if (hit_any) begin
          act_sel = ACT_REMOVE;
        end else begin
          res_status = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd.capture   = (state == S_CMP);
    cmd.act       = finish ? act_sel : ACT_NONE;
    cmd.key       = req_key;
    cmd.key_mask  = kmask;
    cmd.value     = req_value;
    cmd.rank_ref  = hit_rank;
    cmd.last_rank = rank_t'(count - count_t'(1));
    cmd.evict     = evict_now;
  end

  assign hit_chain[0]  = 1'b0;
  assign free_chain[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lkv_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .cmd           (cmd),
      .hit_seen_in   (hit_chain[g]),
      .free_seen_in  (free_chain[g]),
      .hit_seen_out  (hit_chain[g+1]),
      .free_seen_out (free_chain[g+1]),
      .view          (views[g])
    );
  end

  // At most one cell is selected as hit, so an OR over the cells picks the chosen one.
  always_comb begin
    or_rank  = '0;
    or_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_vec[i]   = views[i].hit_sel;
      free_vec[i]  = views[i].free_sel;
      valid_vec[i] = views[i].valid;
      or_rank  = or_rank  | (views[i].hit_sel ? views[i].rank  : '0);
      or_value = or_value | (views[i].hit_sel ? views[i].value : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        out_valid <= 1'b1;
        if ((act_sel == ACT_INSERT) && !evict_now) begin
          count <= count_t'(count + 1'b1);
        end else if (act_sel == ACT_REMOVE) begin
          count <= count_t'(count - 1'b1);
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op    <= req.op;
      req_key   <= req.key & kmask;
      req_value <= req.value & vmask;
    end
    if (state == S_SEL) begin
      hit_any   <= |hit_vec;
      hit_rank  <= or_rank;
      hit_value <= or_value;
    end
    if (finish) begin
      out_status  <= res_status;
      out_value   <= res_value;
      out_evicted <= res_evicted;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("entry count differs from the number of valid cells");

  a_hit_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEL) |-> $onehot0(hit_vec))
    else $error("more than one cell selected as hit");

  a_free_exists: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SEL) && (req_op == OP_UPDATE)) |-> $onehot(free_vec))
    else $error("no single free cell for a possible insert");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_CMP) && !req.ready)
    else $error("accepted request did not start the compare step");
`endif

endmodule
